FILE: rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared widths, operator codes and types for the segmented reduce and
// broadcast block.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int VAL_W       = 32;  // Q16.16 element and result width
  localparam int ORDER_W     = 7;   // segment length field width
  localparam int ROOT_W      = 16;  // stated root index field width
  localparam int OP_W        = 2;   // reduction operator register width
  localparam int QUEUE_DEPTH = 4;   // burst commands between front and back

  // Reduction operator codes; the unused code folds as a sum
  typedef enum logic [OP_W-1:0] {
    OP_SUM = 2'd0,
    OP_MAX = 2'd1,
    OP_MIN = 2'd2
  } op_t;

  // One burst for the back end: a value repeated count times, or one error word
  typedef struct packed {
    logic signed [VAL_W-1:0] reduced;
    logic [ORDER_W-1:0]      count;
    logic                    error;
  } burst_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: rtl/srb_if.sv
// ----------------------------------------------------------------------------
// srb_if
// Valid/ready channels of the segmented reduce and broadcast block: element
// words in, result words out.
// ----------------------------------------------------------------------------
interface srb_in_if import srb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [ORDER_W-1:0]      seg_order;
  logic [ROOT_W-1:0]       root_index;
  logic                    vector_start;

  modport source (output valid, value, seg_order, root_index, vector_start,
                  input ready);
  modport sink   (input valid, value, seg_order, root_index, vector_start,
                  output ready);
endinterface

interface srb_out_if import srb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] reduced;
  logic                    last;
  logic                    error;

  modport source (output valid, reduced, last, error, input ready);
  modport sink   (input valid, reduced, last, error, output ready);
endinterface

FILE: rtl/srb_front.sv
// ----------------------------------------------------------------------------
// srb_front
// Accepts element words, tracks position and segment boundaries, checks the
// root index and folds each segment. Posts one burst command per finished
// or rejected segment.
// ----------------------------------------------------------------------------
module srb_front import srb_pkg::*; #(
  parameter int MAX_ORDER  = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [OP_W-1:0] cfg_data,
  srb_in_if.sink          in_ch,
  input  queue_stat_t     q_stat,
  output logic            push,
  output burst_t          push_data
);

  logic [OP_W-1:0]         reduce_op;
  logic [INDEX_BITS-1:0]   position;
  logic [INDEX_BITS-1:0]   here;
  logic signed [VAL_W-1:0] acc;
  logic signed [VAL_W-1:0] fold_val;
  logic [ORDER_W-1:0]      seg_len;
  logic [ORDER_W-1:0]      remaining;
  logic [ORDER_W-1:0]      rem_dec;
  logic [ORDER_W-1:0]      ord_nz;
  logic [ORDER_W-1:0]      ord;
  logic                    dropping;
  logic                    accept;
  logic                    root_ok;

  // Fold one element into the running value, saturating the sum
  function automatic logic signed [VAL_W-1:0] fold(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic [OP_W-1:0]         op
  );
    logic signed [VAL_W:0]   s;
    logic signed [VAL_W-1:0] r;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    case (op)
      OP_MAX:  r = (a > b) ? a : b;
      OP_MIN:  r = (a < b) ? a : b;
      default: begin
        if (s[VAL_W] != s[VAL_W-1]) begin
          r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          r = s[VAL_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  // Hold the operator register
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_op <= OP_SUM;
    end else if (cfg_we) begin
      reduce_op <= cfg_data;
    end
  end

  // Classify the word in front
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign here        = in_ch.vector_start ? '0 : position;
  assign ord_nz      = (in_ch.seg_order == '0) ? ORDER_W'(1) : in_ch.seg_order;
  assign ord         = (int'(ord_nz) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : ord_nz;
  assign root_ok     = (32'(in_ch.root_index) == 32'(here));
  assign rem_dec     = remaining - ORDER_W'(1);
  assign fold_val    = fold(acc, in_ch.value, reduce_op);

  // Post a burst when a segment completes or its root is rejected
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (accept) begin
      if (remaining == '0) begin
        if (!root_ok) begin
          push              = 1'b1;
          push_data.count   = ORDER_W'(1);
          push_data.error   = 1'b1;
        end else if (ord == ORDER_W'(1)) begin
          push              = 1'b1;
          push_data.reduced = in_ch.value;
          push_data.count   = ORDER_W'(1);
        end
      end else if (!dropping && rem_dec == '0) begin
        push              = 1'b1;
        push_data.reduced = fold_val;
        push_data.count   = seg_len;
      end
    end
  end

  // Advance position and segment state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      acc       <= '0;
      seg_len   <= '0;
      remaining <= '0;
      dropping  <= 1'b0;
    end else if (accept) begin
      position <= here + INDEX_BITS'(1);
      if (remaining == '0) begin
        seg_len   <= ord;
        remaining <= ord - ORDER_W'(1);
        if (!root_ok) begin
          dropping <= (ord != ORDER_W'(1));
        end else begin
          dropping <= 1'b0;
          acc      <= in_ch.value;
        end
      end else begin
        remaining <= rem_dec;
        if (dropping) begin
          if (rem_dec == '0) begin
            dropping <= 1'b0;
          end
        end else begin
          acc <= fold_val;
        end
      end
    end
  end

endmodule

FILE: rtl/srb_queue.sv
// ----------------------------------------------------------------------------
// srb_queue
// Short ring of burst commands that decouples the front from the back.
// ----------------------------------------------------------------------------
module srb_queue import srb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  burst_t      push_data,
  input  logic        pop,
  output burst_t      head,
  output queue_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  burst_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/srb_back.sv
// ----------------------------------------------------------------------------
// srb_back
// Expands each burst command into result words, one per cycle while out_ch is ready,
// through a registered output stage.
// ----------------------------------------------------------------------------
module srb_back import srb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  burst_t      head,
  input  queue_stat_t q_stat,
  output logic        pop,
  srb_out_if.source   out_ch
);

  logic                    out_valid;
  logic [ORDER_W-1:0]      left;
  logic signed [VAL_W-1:0] hold_val;
  logic                    slot_free;

  assign out_ch.valid = out_valid;
  assign slot_free    = !out_valid || out_ch.ready;
  assign pop          = slot_free && (left == '0) && !q_stat.empty;

  // Track the output valid and the words left in the current burst
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= '0;
    end else if (slot_free) begin
      if (left != '0) begin
        out_valid <= 1'b1;
        left      <= left - ORDER_W'(1);
      end else if (!q_stat.empty) begin
        out_valid <= 1'b1;
        left      <= head.count - ORDER_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (left != '0) begin
        out_ch.reduced <= hold_val;
        out_ch.last    <= (left == ORDER_W'(1));
        out_ch.error   <= 1'b0;
      end else if (!q_stat.empty) begin
        out_ch.reduced <= head.reduced;
        out_ch.last    <= (head.count == ORDER_W'(1));
        out_ch.error   <= head.error;
        hold_val       <= head.reduced;
      end
    end
  end

endmodule

FILE: rtl/segmented_reduce_broadcast.sv
// ----------------------------------------------------------------------------
// segmented_reduce_broadcast
// Segmented sum, maximum or minimum over a stream of Q16.16 elements, with
// the result repeated once per segment member.
// ----------------------------------------------------------------------------
// Element words enter on in_ch (valid/ready). The first word of a segment
// carries its length and stated root index; a root that disagrees with the
// running position gives one result word with error and last set, and the
// rest of that segment is swallowed. Otherwise, on the segment's last word,
// the folded value is sent on out_ch once per member, last set on the final.
// cfg_we/cfg_data write the operator: 0 sum (saturating), 1 maximum,
// 2 minimum; write it only while the block is idle.
// Throughput: one element accepted per cycle while the queue has room, one
// result word sent per cycle while out_ch is ready. A finished segment passes
// the command queue and the registered output stage; its burst follows gapless.
// A four-entry command queue sits between the folding front end and the
// expanding back end, so in_ch keeps flowing while out_ch is stalled until
// the queue fills; a stalled result word holds on out_ch.
// Reset clears position, segment state, the queue and the operator (sum).
// ----------------------------------------------------------------------------
module segmented_reduce_broadcast import srb_pkg::*; #(
  parameter int MAX_ORDER  = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [OP_W-1:0] cfg_data,
  srb_in_if.sink          in_ch,
  srb_out_if.source       out_ch
);

  logic        push;
  logic        pop;
  burst_t      push_data;
  burst_t      head;
  queue_stat_t q_stat;

  srb_front #(
    .MAX_ORDER (MAX_ORDER),
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  srb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  srb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

  // Error word is a lone, zero-valued final word
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.error |-> out_ch.last && out_ch.reduced == '0)
    else $error("error word without last or with nonzero value");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("burst pushed into full queue");

  // A burst runs without gaps once started
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside result burst");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

FILE: test/segmented_reduce_broadcast_tb.sv
// ----------------------------------------------------------------------------
// segmented_reduce_broadcast_tb
// Self-checking bench for the segmented sum/max/min with per-member broadcast.
// A table of directed element words runs first. It covers the value extremes,
// saturation both ways, each operator including the spare code, zero length,
// root errors and non-member fields, vector start inside a segment, and an
// operator change within a segment. Phases of random segments follow. Most
// are well formed, a few carry bad roots or noise, and some have the largest
// and clamped lengths. A local model predicts every result word, and each
// word received is checked against the oldest prediction. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module segmented_reduce_broadcast_tb import srb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER   = 64;
  localparam int INDEX_BITS  = 16;
  localparam int ITEMS       = 500;
  localparam int DRAIN       = 8;       // cycles before an operator write
  localparam int END_WAIT    = 32;      // cycles to catch stray result words
  localparam int SHOWN       = 10;      // mismatches reported in full
  localparam int DIR_ROWS    = 23;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, folds as sum

  typedef struct packed {
    logic signed [VAL_W-1:0] reduced;
    logic                    last;
    logic                    err;
  } res_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ORDER_W-1:0]      order;
    logic [ROOT_W-1:0]       root;
    logic                    vstart;
  } elem_t;

  typedef struct packed {
    logic            has_cfg;
    logic [OP_W-1:0] cfg;
    elem_t           elem;
    logic            typed;
    res_word_t       res;
  } row_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [OP_W-1:0] cfg_data;

  srb_in_if  in_ch ();
  srb_out_if out_ch ();

  segmented_reduce_broadcast #(
    .MAX_ORDER  (MAX_ORDER),
    .INDEX_BITS (INDEX_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Model state of the segment folder
  logic [OP_W-1:0]         m_op;
  logic [INDEX_BITS-1:0]   m_pos;
  logic signed [VAL_W-1:0] m_acc;
  logic [ORDER_W-1:0]      m_len;
  logic [ORDER_W-1:0]      m_left;
  logic                    m_skip;

  res_word_t expected_words [$];
  res_word_t head_word;
  row_t      dir_rows [DIR_ROWS];
  int        mismatches;
  int        taken;
  longint    cycles;
  logic      in_idle;
  logic      out_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fold two elements with the operator currently set
  function automatic logic signed [VAL_W-1:0] combine(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    case (m_op)
      OP_MAX: combine = (a > b) ? a : b;
      OP_MIN: combine = (a < b) ? a : b;
      default: begin
        if (s[VAL_W] != s[VAL_W-1])
          combine = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
          combine = s[VAL_W-1:0];
      end
    endcase
  endfunction

  // Advance the folder by one accepted word; queue the result words it causes
  function automatic int reduce_element(input elem_t w);
    logic [INDEX_BITS-1:0] here;
    logic [ORDER_W-1:0]    n;
    res_word_t             rw;
    int                    k;
    if (w.vstart)
      m_pos = '0;
    here  = m_pos;
    m_pos = m_pos + INDEX_BITS'(1);
    if (m_left == 0) begin
      n = w.order;
      if (n == 0)
        n = ORDER_W'(1);
      if (n > MAX_ORDER)
        n = ORDER_W'(MAX_ORDER);
      m_len  = n;
      m_left = n - ORDER_W'(1);
      // Bad root: one error word, drop the rest of the segment
      if (w.root != here) begin
        m_skip = (m_left != 0);
        rw = '{'0, 1'b1, 1'b1};
        expected_words.insert(expected_words.size(), rw);
        return 1;
      end
      m_skip = 1'b0;
      m_acc  = w.value;
    end else begin
      m_left = m_left - ORDER_W'(1);
      if (m_skip) begin
        if (m_left == 0)
          m_skip = 1'b0;
        return 0;
      end
      m_acc = combine(m_acc, w.value);
    end
    if (m_left != 0)
      return 0;
    // Broadcast the folded value once per member
    for (k = 0; k < m_len; k++) begin
      rw = '{m_acc, (k == m_len - 1), 1'b0};
      expected_words.insert(expected_words.size(), rw);
    end
    return int'(m_len);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input logic busy);
    int r;
    r = $urandom_range(0, 99);
    if (!busy || r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return 32'sh7FFFFFFF;
    if (r < 8)
      return 32'sh80000000;
    if (r < 10)
      return 32'sh00000000;
    if (r < 50)
      return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
    return $urandom;
  endfunction

  // Offer one element word after a gap; hold it until taken, then predict
  task automatic send_word(input elem_t w, input int gap, output int produced);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.value        <= w.value;
    in_ch.seg_order    <= w.order;
    in_ch.root_index   <= w.root;
    in_ch.vector_start <= w.vstart;
    do @(posedge clk); while (!in_ch.ready);
    taken++;
    produced = reduce_element(w);
  endtask

  // Write the operator once the block has gone quiet
  task automatic write_op(input logic [OP_W-1:0] op);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= op;
    @(negedge clk);
    cfg_we   <= 1'b0;
    m_op = op;
  endtask

  // One segment: a first word, then members until the folder wants no more
  task automatic send_segment(input int forced_order);
    elem_t                 w;
    int                    r;
    int                    produced;
    logic [INDEX_BITS-1:0] due;
    r = $urandom_range(0, 99);
    w.vstart = ($urandom_range(0, 19) == 0);
    if (forced_order >= 0)
      w.order = ORDER_W'(forced_order);
    else if (r < 58)
      w.order = ORDER_W'($urandom_range(1, 4));
    else if (r < 83)
      w.order = ORDER_W'($urandom_range(5, 16));
    else if (r < 90)
      w.order = ORDER_W'($urandom_range(17, MAX_ORDER - 1));
    else if (r < 92)
      w.order = ORDER_W'(MAX_ORDER);
    else if (r < 94)
      w.order = ORDER_W'($urandom_range(MAX_ORDER + 1, 127));
    else if (r < 96)
      w.order = '0;
    else
      w.order = ORDER_W'($urandom);
    due = w.vstart ? '0 : m_pos;
    // Mostly the right root; now and then a broken one
    if ($urandom_range(0, 99) < 8 || r >= 96) begin
      w.root = ROOT_W'($urandom);
      if (w.root == due)
        w.root = ~due;
    end else begin
      w.root = due;
    end
    w.value = pick_value();
    send_word(w, pick_gap(in_idle), produced);
    while (m_left != 0) begin
      w.value  = pick_value();
      w.order  = ORDER_W'($urandom);
      w.root   = ROOT_W'($urandom);
      w.vstart = ($urandom_range(0, 29) == 0);
      send_word(w, pick_gap(in_idle), produced);
    end
  endtask

  // Count cycles and check every result word taken
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        if (mismatches < SHOWN)
          $display("unexpected result word: reduced %h last %b error %b",
                   out_ch.reduced, out_ch.last, out_ch.error);
        mismatches++;
      end else begin
        head_word = expected_words.pop_front();
        if (out_ch.reduced !== head_word.reduced || out_ch.last !== head_word.last ||
            out_ch.error !== head_word.err) begin
          if (mismatches < SHOWN)
            $display("result mismatch: expected %h/%b/%b, got %h/%b/%b (reduced/last/error)",
                     head_word.reduced, head_word.last, head_word.err,
                     out_ch.reduced, out_ch.last, out_ch.error);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side at random
  initial begin : out_pacing
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && out_idle && $urandom_range(0, 2) == 0)
        hold = pick_gap(1'b1);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    row_t            row;
    res_word_t       spare_word;
    int              produced;
    int              phase;
    int              goal;
    int              first;
    logic [OP_W-1:0] op;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = OP_SUM;
    in_ch.valid        = 1'b0;
    in_ch.value        = '0;
    in_ch.seg_order    = '0;
    in_ch.root_index   = '0;
    in_ch.vector_start = 1'b0;
    in_idle            = 1'b1;
    out_idle           = 1'b1;
    mismatches         = 0;
    taken              = 0;
    cycles             = 0;
    m_op   = OP_SUM;
    m_pos  = '0;
    m_acc  = '0;
    m_len  = '0;
    m_left = '0;
    m_skip = 1'b0;

    // Directed words: {cfg?, op, {value, order, root, vstart}, typed?, {reduced, last, error}}
    // Single words, operator at reset: largest and smallest value, zero length
    dir_rows[0]  = '{1'b0, OP_SUM, '{32'sh7FFFFFFF, 7'd1, 16'd0, 1'b0}, 1'b1,
                     '{32'sh7FFFFFFF, 1'b1, 1'b0}};
    dir_rows[1]  = '{1'b0, OP_SUM, '{32'sh80000000, 7'd0, 16'd1, 1'b0}, 1'b1,
                     '{32'sh80000000, 1'b1, 1'b0}};
    // Bad root on a one-word segment, then on a three-word one
    dir_rows[2]  = '{1'b0, OP_SUM, '{32'sh00000005, 7'd1, 16'hFFFF, 1'b0}, 1'b1,
                     '{32'sh0, 1'b1, 1'b1}};
    dir_rows[3]  = '{1'b0, OP_SUM, '{32'sh00000007, 7'd3, 16'd0, 1'b0}, 1'b1,
                     '{32'sh0, 1'b1, 1'b1}};
    dir_rows[4]  = '{1'b0, OP_SUM, '{32'sh00000009, 7'h55, 16'hAAAA, 1'b0}, 1'b0, '0};
    dir_rows[5]  = '{1'b0, OP_SUM, '{32'sh0000000B, 7'h2A, 16'h5555, 1'b0}, 1'b0, '0};
    // Saturate upwards, then downwards; member fields are junk
    dir_rows[6]  = '{1'b0, OP_SUM, '{32'sh7FFFFFFF, 7'd2, 16'd6, 1'b0}, 1'b0, '0};
    dir_rows[7]  = '{1'b0, OP_SUM, '{32'sh00000001, 7'h7F, 16'h1234, 1'b0}, 1'b0, '0};
    dir_rows[8]  = '{1'b0, OP_SUM, '{32'sh80000000, 7'd2, 16'd8, 1'b0}, 1'b0, '0};
    dir_rows[9]  = '{1'b0, OP_SUM, '{32'shFFFFFFFF, 7'd0, 16'hFFFF, 1'b0}, 1'b0, '0};
    // Vector start inside a segment resets only the position
    dir_rows[10] = '{1'b0, OP_SUM, '{32'sh00010000, 7'd3, 16'd10, 1'b0}, 1'b0, '0};
    dir_rows[11] = '{1'b0, OP_SUM, '{32'sh00020000, 7'd1, 16'd3, 1'b1}, 1'b0, '0};
    dir_rows[12] = '{1'b0, OP_SUM, '{32'shFFFF0000, 7'd9, 16'd0, 1'b0}, 1'b0, '0};
    dir_rows[13] = '{1'b0, OP_SUM, '{32'sh12345678, 7'd1, 16'd0, 1'b1}, 1'b1,
                     '{32'sh12345678, 1'b1, 1'b0}};
    // Maximum, then minimum from the middle of the same segment
    dir_rows[14] = '{1'b1, OP_MAX, '{32'sh80000000, 7'd3, 16'd1, 1'b0}, 1'b0, '0};
    dir_rows[15] = '{1'b0, OP_MAX, '{32'sh7FFFFFFF, 7'd0, 16'd0, 1'b0}, 1'b0, '0};
    dir_rows[16] = '{1'b1, OP_MIN, '{32'sh00000005, 7'd0, 16'd0, 1'b0}, 1'b0, '0};
    // Spare operator code folds as a sum
    dir_rows[17] = '{1'b1, OP_SPARE, '{32'sh00000003, 7'd2, 16'd4, 1'b0}, 1'b0, '0};
    dir_rows[18] = '{1'b0, OP_SPARE, '{32'sh00000004, 7'd2, 16'd4, 1'b0}, 1'b0, '0};
    // Minimum and maximum at the value extremes
    dir_rows[19] = '{1'b1, OP_MIN, '{32'sh7FFFFFFF, 7'd2, 16'd6, 1'b0}, 1'b0, '0};
    dir_rows[20] = '{1'b0, OP_MIN, '{32'sh80000000, 7'd2, 16'd6, 1'b0}, 1'b0, '0};
    dir_rows[21] = '{1'b1, OP_MAX, '{32'sh80000000, 7'd2, 16'd8, 1'b0}, 1'b0, '0};
    dir_rows[22] = '{1'b0, OP_MAX, '{32'sh80000001, 7'd2, 16'd8, 1'b0}, 1'b0, '0};

    // Hold reset, then release on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; typed rows replace the model's words with their own
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.has_cfg)
        write_op(row.cfg);
      send_word(row.elem, (i % 4 == 3) ? pick_gap(1'b1) : 0, produced);
      if (row.typed) begin
        repeat (produced) spare_word = expected_words.pop_back();
        expected_words.insert(expected_words.size(), row.res);
      end
    end

    // Random phases, each under one operator and one idling mix
    phase = 0;
    while (taken < ITEMS) begin
      op = (phase < 4) ? phase[OP_W-1:0] : OP_W'($urandom_range(0, 3));
      write_op(op);
      in_idle  = (phase % 3 != 1);
      out_idle = (phase % 3 != 2);
      goal  = taken + $urandom_range(30, 80);
      first = (phase == 1) ? 127 : (phase == 2) ? MAX_ORDER : -1;
      send_segment(first);
      while (taken < goal)
        send_segment(-1);
      phase++;
    end

    // Drain and decide
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
